>>> sv/tzgd_pkg.sv
// Shared types, codes and constants of the touch zone gesture detector.
package tzgd_pkg;

    localparam int FINGERS_DEF = 2;
    localparam int ZONE_SLOTS  = 10;
    localparam int ZONE_W      = 4;
    localparam int POS_W       = 12;
    localparam int TIME_W      = 32;
    localparam int WINDOW_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Percent band edges of the 3x3 grid
    localparam int PCT_SCALE = 100;
    localparam int BAND_LO   = 33;
    localparam int BAND_HI   = 67;

    localparam logic [POS_W-1:0]    WIDTH_RST  = 12'd1920;
    localparam logic [POS_W-1:0]    HEIGHT_RST = 12'd1080;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd150;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_WINDOW  = 2'd2;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_EVENT = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_UP   = 2'd1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        event_type;
        logic [3:0]        finger;
        logic [POS_W-1:0]  x_pos;
        logic [POS_W-1:0]  y_pos;
        logic [ZONE_W-1:0] zone_a;
        logic [ZONE_W-1:0] zone_b;
        logic [TIME_W-1:0] min_time;
        logic [TIME_W-1:0] max_time;
    } item_word_t;

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic              touched;
        logic              held;
        logic              slid;
    } result_word_t;

    typedef struct packed {
        logic touched;
        logic held;
        logic slid;
    } flags_t;

endpackage

>>> sv/tzgd_if.sv
// Valid/ready channel interfaces for input items and result words.
interface tzgd_item_if;
    logic                 valid;
    logic                 ready;
    tzgd_pkg::item_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tzgd_result_if;
    logic                   valid;
    logic                   ready;
    tzgd_pkg::result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/touch_zone_gesture_detector.sv
// Top level of the touch zone gesture detector: registers, handshake and assertions.
// Takes one item per clock unless a stalled result and a full input register hold it off:
// a tick advances the 32-bit time and gives no result, a touch event gives one word with
// its zone (1..9, column-major) and cleared flags, a query gives one word with zone 0 and
// the touched, held and slid flags. A word is accepted into an input register, evaluated
// against the stored stamps and finger records and placed in the result register once that
// register is free or draining, and it leaves from there when the result side is ready;
// input and result registers decouple both sides and a stalled result only blocks new
// items once the input register is also full. Configuration writes through cfg_we,
// cfg_index and cfg_data take effect at the next edge and belong to an idle block.
module touch_zone_gesture_detector #(
    parameter int FINGERS = tzgd_pkg::FINGERS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tzgd_item_if.sink                          item,
    tzgd_result_if.source                      result,
    input  logic                               cfg_we,
    input  logic [tzgd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tzgd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PW = tzgd_pkg::POS_W;
    localparam int WW = tzgd_pkg::WINDOW_W;

    logic [PW-1:0]          width_reg;
    logic [PW-1:0]          height_reg;
    logic [WW-1:0]          window_reg;

    logic                   s1_valid_reg;
    tzgd_pkg::item_word_t   s1_word_reg;
    logic                   res_valid_reg;
    tzgd_pkg::result_word_t res_word_reg;

    logic                   advance;
    logic                   fire;
    logic                   has_result;
    logic [tzgd_pkg::ZONE_W-1:0] zone;
    tzgd_pkg::flags_t       flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tzgd_pkg::WIDTH_RST;
            height_reg <= tzgd_pkg::HEIGHT_RST;
            window_reg <= tzgd_pkg::WINDOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tzgd_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_data[PW-1:0];
                tzgd_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_data[PW-1:0];
                tzgd_pkg::CFG_TOUCH_WINDOW:  window_reg <= cfg_data[WW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // the evaluation stage moves whenever the result register is free or draining
    assign advance    = !res_valid_reg || result.ready;
    assign fire       = s1_valid_reg && advance;
    assign item.ready = !s1_valid_reg || advance;
    assign has_result = (s1_word_reg.cmd == tzgd_pkg::CMD_EVENT)
                     || (s1_word_reg.cmd == tzgd_pkg::CMD_QUERY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                s1_valid_reg <= item.valid;
            if (advance)
                res_valid_reg <= fire && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            s1_word_reg <= item.data;
        if (advance)
        begin
            if (s1_word_reg.cmd == tzgd_pkg::CMD_EVENT)
            begin
                res_word_reg.zone    <= zone;
                res_word_reg.touched <= 1'b0;
                res_word_reg.held    <= 1'b0;
                res_word_reg.slid    <= 1'b0;
            end
            else
            begin
                res_word_reg.zone    <= '0;
                res_word_reg.touched <= flags.touched;
                res_word_reg.held    <= flags.held;
                res_word_reg.slid    <= flags.slid;
            end
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_word_reg;

    tzgd_zone u_zone (
        .x_pos         (s1_word_reg.x_pos),
        .y_pos         (s1_word_reg.y_pos),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .zone          (zone)
    );

    tzgd_core #(
        .FINGERS (FINGERS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (fire),
        .word         (s1_word_reg),
        .zone         (zone),
        .touch_window (window_reg),
        .flags        (flags)
    );

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && res_valid_reg && !result.ready |-> !item.ready)
        else $error("input taken while evaluation stage is stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && has_result |=> result.valid)
        else $error("event or query produced no result word");

    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (s1_word_reg.cmd == tzgd_pkg::CMD_TICK) |=> !result.valid)
        else $error("tick produced a result word");

    a_event_word: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.data.zone != 4'd0) |->
        (result.data.zone <= 4'd9) && !result.data.touched && !result.data.held
        && !result.data.slid)
        else $error("malformed event result word");

endmodule

>>> sv/tzgd_zone.sv
// Grid zone classifier: maps a touch coordinate onto the 3x3 zone grid.
module tzgd_zone (
    input  logic [tzgd_pkg::POS_W-1:0]  x_pos,
    input  logic [tzgd_pkg::POS_W-1:0]  y_pos,
    input  logic [tzgd_pkg::POS_W-1:0]  screen_width,
    input  logic [tzgd_pkg::POS_W-1:0]  screen_height,
    output logic [tzgd_pkg::ZONE_W-1:0] zone
);

    localparam int PROD_W = 19;

    function automatic logic [1:0] grid_band(
        input logic [tzgd_pkg::POS_W-1:0] pos,
        input logic [tzgd_pkg::POS_W-1:0] extent
    );
        logic [PROD_W-1:0] scaled;
        logic [PROD_W-1:0] lo_edge;
        logic [PROD_W-1:0] hi_edge;
        logic [1:0]        band;
        scaled  = PROD_W'(pos) * PROD_W'(tzgd_pkg::PCT_SCALE);
        lo_edge = PROD_W'(extent) * PROD_W'(tzgd_pkg::BAND_LO);
        hi_edge = PROD_W'(extent) * PROD_W'(tzgd_pkg::BAND_HI);
        if (scaled < lo_edge)
            band = 2'd0;
        else if (scaled < hi_edge)
            band = 2'd1;
        else
            band = 2'd2;
        return band;
    endfunction

    logic [1:0] col;
    logic [1:0] row;

    assign col = grid_band(x_pos, screen_width);
    assign row = grid_band(y_pos, screen_height);

    // column-major numbering, 1 at top-left
    assign zone = {2'b00, col} * 4'd3 + {2'b00, row} + 4'd1;

endmodule

>>> sv/tzgd_core.sv
// Tick time, zone stamps, finger records and gesture flag evaluation.
module tzgd_core #(
    parameter int FINGERS = tzgd_pkg::FINGERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  tzgd_pkg::item_word_t           word,
    input  logic [tzgd_pkg::ZONE_W-1:0]    zone,
    input  logic [tzgd_pkg::WINDOW_W-1:0]  touch_window,
    output tzgd_pkg::flags_t               flags
);

    localparam int TW = tzgd_pkg::TIME_W;
    localparam int ZW = tzgd_pkg::ZONE_W;

    logic [TW-1:0] now_reg;
    logic [TW-1:0] stamp_reg     [tzgd_pkg::ZONE_SLOTS];
    logic [ZW-1:0] down_zone_reg [FINGERS];
    logic [TW-1:0] down_time_reg [FINGERS];
    logic [ZW-1:0] up_zone_reg   [FINGERS];
    logic [TW-1:0] up_time_reg   [FINGERS];

    logic [TW-1:0] window;

    assign window = TW'(touch_window);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            for (int z = 0; z < tzgd_pkg::ZONE_SLOTS; z++)
            begin
                stamp_reg[z] <= '0;
            end
            for (int i = 0; i < FINGERS; i++)
            begin
                down_zone_reg[i] <= '0;
                down_time_reg[i] <= '0;
                up_zone_reg[i]   <= '0;
                up_time_reg[i]   <= '0;
            end
        end
        else if (en)
        begin
            case (word.cmd)
                tzgd_pkg::CMD_TICK:
                begin
                    now_reg <= now_reg + TW'(1);
                end
                tzgd_pkg::CMD_EVENT:
                begin
                    stamp_reg[zone] <= now_reg;
                    // only tracked fingers match a slot; others just stamp the zone
                    for (int i = 0; i < FINGERS; i++)
                    begin
                        if ({1'b0, word.finger} == 5'(i))
                        begin
                            if (word.event_type == tzgd_pkg::EV_DOWN)
                            begin
                                down_zone_reg[i] <= zone;
                                down_time_reg[i] <= now_reg;
                            end
                            else if (word.event_type == tzgd_pkg::EV_UP)
                            begin
                                up_zone_reg[i] <= zone;
                                up_time_reg[i] <= now_reg;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        logic [TW-1:0] touch_end;
        logic [TW-1:0] hold_end;
        logic [TW-1:0] slide_end;
        logic [TW-1:0] dur;
        flags = '0;
        touch_end = '0;
        if (word.zone_a < ZW'(tzgd_pkg::ZONE_SLOTS))
        begin
            touch_end = stamp_reg[word.zone_a] + window;
            flags.touched = touch_end > now_reg;
        end
        for (int i = 0; i < FINGERS; i++)
        begin
            hold_end  = down_time_reg[i] + word.min_time;
            slide_end = up_time_reg[i] + window;
            dur       = up_time_reg[i] - down_time_reg[i];
            if (down_zone_reg[i] == word.zone_a && up_time_reg[i] < down_time_reg[i]
                && hold_end <= now_reg)
                flags.held = 1'b1;
            if (down_zone_reg[i] == word.zone_a && up_zone_reg[i] == word.zone_b
                && up_time_reg[i] > down_time_reg[i] && slide_end > now_reg
                && dur >= word.min_time && dur <= word.max_time)
                flags.slid = 1'b1;
        end
    end

endmodule

>>> tb/tzgd_gesture_checker.sv
// Checker for the touch zone gesture detector: tracks grid stamps and finger records, compares words.
module tzgd_gesture_checker
    import tzgd_pkg::*;
#(
    parameter int FINGERS = FINGERS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tzgd_item_if                  item,
    tzgd_result_if                result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    outstanding,
    output int                    mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [POS_W-1:0]    width_cfg;
    logic [POS_W-1:0]    height_cfg;
    logic [WINDOW_W-1:0] window_cfg;

    logic [TIME_W-1:0] now_t;
    logic [TIME_W-1:0] stamp [ZONE_SLOTS];
    logic [ZONE_W-1:0] down_z [FINGERS];
    logic [TIME_W-1:0] down_t [FINGERS];
    logic [ZONE_W-1:0] up_z [FINGERS];
    logic [TIME_W-1:0] up_t [FINGERS];

    result_word_t answer_q [$];
    result_word_t want;
    int           bad_count = 0;

    assign outstanding = answer_q.size();
    assign mismatches  = bad_count;

    function automatic logic [1:0] band_of(input logic [POS_W-1:0] pos,
                                           input logic [POS_W-1:0] extent);
        logic [31:0] scaled;
        scaled = 32'(pos) * 32'(PCT_SCALE);
        if (scaled < 32'(BAND_LO) * 32'(extent))
            return 2'd0;
        if (scaled < 32'(BAND_HI) * 32'(extent))
            return 2'd1;
        return 2'd2;
    endfunction

    // Update the tracked state with one accepted word and queue its answer, if any
    task automatic track_item(input item_word_t w);
        result_word_t      ans;
        logic [ZONE_W-1:0] z;
        logic [TIME_W-1:0] span;
        ans = '0;
        case (w.cmd)
            CMD_TICK:
            begin
                now_t = now_t + 32'd1;
            end
            CMD_EVENT:
            begin
                z = ZONE_W'(band_of(w.x_pos, width_cfg) * 3
                            + band_of(w.y_pos, height_cfg) + 1);
                stamp[z] = now_t;
                if (w.finger < FINGERS)
                begin
                    if (w.event_type == EV_DOWN)
                    begin
                        down_z[w.finger] = z;
                        down_t[w.finger] = now_t;
                    end
                    else if (w.event_type == EV_UP)
                    begin
                        up_z[w.finger] = z;
                        up_t[w.finger] = now_t;
                    end
                end
                ans.zone = z;
                answer_q.push_back(ans);
            end
            CMD_QUERY:
            begin
                if (w.zone_a < ZONE_SLOTS)
                    ans.touched = (stamp[w.zone_a] + 32'(window_cfg)) > now_t;
                for (int f = 0; f < FINGERS; f++)
                begin
                    if (down_z[f] == w.zone_a && up_t[f] < down_t[f]
                        && (down_t[f] + w.min_time) <= now_t)
                        ans.held = 1'b1;
                    if (down_z[f] == w.zone_a && up_z[f] == w.zone_b && up_t[f] > down_t[f]
                        && (up_t[f] + 32'(window_cfg)) > now_t)
                    begin
                        span = up_t[f] - down_t[f];
                        if (span >= w.min_time && span <= w.max_time)
                            ans.slid = 1'b1;
                    end
                end
                answer_q.push_back(ans);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg  = WIDTH_RST;
            height_cfg = HEIGHT_RST;
            window_cfg = WINDOW_RST;
            now_t      = '0;
            for (int i = 0; i < ZONE_SLOTS; i++)
                stamp[i] = '0;
            for (int f = 0; f < FINGERS; f++)
            begin
                down_z[f] = '0;
                down_t[f] = '0;
                up_z[f]   = '0;
                up_t[f]   = '0;
            end
            answer_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  width_cfg  = cfg_data[POS_W-1:0];
                    CFG_SCREEN_HEIGHT: height_cfg = cfg_data[POS_W-1:0];
                    CFG_TOUCH_WINDOW:  window_cfg = cfg_data[WINDOW_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (item.valid && item.ready)
                track_item(item.data);
            if (result.valid && result.ready)
            begin
                if (answer_q.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: result word zone %0d t%0b h%0b s%0b with nothing pending",
                                 $time, result.data.zone, result.data.touched,
                                 result.data.held, result.data.slid);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (want.zone !== result.data.zone || want.touched !== result.data.touched
                        || want.held !== result.data.held || want.slid !== result.data.slid)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("%0t: expected zone %0d t%0b h%0b s%0b, got zone %0d t%0b h%0b s%0b",
                                     $time, want.zone, want.touched, want.held, want.slid,
                                     result.data.zone, result.data.touched,
                                     result.data.held, result.data.slid);
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for the touch zone gesture detector: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tzgd_pkg::*;

    localparam logic [1:0]           EV_MOVE    = 2'd2;
    localparam logic [1:0]           EV_OTHER   = 2'd3;
    localparam logic [1:0]           CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  ready_q = 1'b0;

    int gap_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int outstanding;
    int mismatches;

    logic [POS_W-1:0] cur_w = WIDTH_RST;
    logic [POS_W-1:0] cur_h = HEIGHT_RST;

    tzgd_item_if   item_ch ();
    tzgd_result_if result_ch ();

    assign result_ch.ready = ready_q;

    touch_zone_gesture_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tzgd_gesture_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        ready_q <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic item_word_t noise_word();
        item_word_t w;
        w.cmd        = 2'($urandom_range(3));
        w.event_type = 2'($urandom_range(3));
        w.finger     = 4'($urandom_range(15));
        w.x_pos      = POS_W'($urandom_range(4095));
        w.y_pos      = POS_W'($urandom_range(4095));
        w.zone_a     = ZONE_W'($urandom_range(15));
        w.zone_b     = ZONE_W'($urandom_range(15));
        w.min_time   = $urandom();
        w.max_time   = $urandom();
        return w;
    endfunction

    function automatic logic [POS_W-1:0] coord_in(input int band, input logic [POS_W-1:0] extent);
        int pct;
        case (band)
            0:       pct = $urandom_range(0, 30);
            1:       pct = $urandom_range(36, 64);
            default: pct = $urandom_range(70, 99);
        endcase
        return POS_W'((int'(extent) * pct) / 100);
    endfunction

    // Hold valid until the word is taken; idle first at the current gap rate
    task automatic send_word(input item_word_t w);
        while ($urandom_range(99) < gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= w;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        item_word_t w;
        repeat (n)
        begin
            w = noise_word();
            w.cmd = CMD_TICK;
            send_word(w);
        end
    endtask

    task automatic send_touch(input logic [1:0] ev, input logic [3:0] fng,
                              input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        item_word_t w;
        w = noise_word();
        w.cmd        = CMD_EVENT;
        w.event_type = ev;
        w.finger     = fng;
        w.x_pos      = x;
        w.y_pos      = y;
        send_word(w);
    endtask

    task automatic send_query(input logic [ZONE_W-1:0] za, input logic [ZONE_W-1:0] zb,
                              input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
        item_word_t w;
        w = noise_word();
        w.cmd      = CMD_QUERY;
        w.zone_a   = za;
        w.zone_b   = zb;
        w.min_time = lo;
        w.max_time = hi;
        send_word(w);
    endtask

    // Down on one zone, wait, maybe lift on any zone, then ask about it with bounds near the span
    task automatic send_gesture();
        logic [3:0]        fng;
        logic [ZONE_W-1:0] za;
        logic [ZONE_W-1:0] zb;
        int                ca, ra, cb, rb, hold;
        fng  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1));
        ca   = $urandom_range(2);
        ra   = $urandom_range(2);
        cb   = $urandom_range(2);
        rb   = $urandom_range(2);
        za   = ZONE_W'(3 * ca + ra + 1);
        zb   = ZONE_W'(3 * cb + rb + 1);
        hold = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(10);
        send_touch(EV_DOWN, fng, coord_in(ca, cur_w), coord_in(ra, cur_h));
        send_ticks(hold);
        if ($urandom_range(1) == 1)
            send_query(za, ZONE_W'($urandom_range(1, 9)),
                       32'(hold) + 32'($urandom_range(4)) - 32'd2, $urandom());
        if ($urandom_range(5) != 0)
        begin
            send_touch(EV_UP, fng, coord_in(cb, cur_w), coord_in(rb, cur_h));
            send_ticks($urandom_range(6));
        end
        send_query(za, zb, 32'(hold) + 32'($urandom_range(4)) - 32'd2,
                   32'(hold) + 32'($urandom_range(5)) - 32'd2);
    endtask

    task automatic run_random(input int count);
        item_word_t w;
        int         first;
        int         pick;
        first = items_sent;
        while (items_sent - first < count)
        begin
            pick = $urandom_range(99);
            if (pick < 28)
                send_ticks(($urandom_range(29) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(1, 5));
            else if (pick < 55)
                send_gesture();
            else if (pick < 72)
            begin
                w = noise_word();
                w.cmd = CMD_QUERY;
                if ($urandom_range(15) != 0)
                begin
                    w.zone_a = ZONE_W'($urandom_range(1, 9));
                    w.zone_b = ZONE_W'($urandom_range(1, 9));
                end
                if ($urandom_range(7) != 0)
                begin
                    w.min_time = $urandom_range(40);
                    w.max_time = $urandom_range(80);
                end
                send_word(w);
            end
            else if (pick < 90)
            begin
                w = noise_word();
                w.cmd = CMD_EVENT;
                if ($urandom_range(3) != 0)
                    w.finger = 4'($urandom_range(1));
                send_word(w);
            end
            else
                send_word(noise_word());
        end
    endtask

    // Write all registers back to back on an idle block, optionally poke the unused index
    task automatic write_settings(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] ht,
                                  input logic [CFG_DATA_W-1:0] win, input bit stray);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= wd;
        @(posedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= ht;
        @(posedge clk);
        cfg_index <= CFG_TOUCH_WINDOW;
        cfg_data  <= win;
        @(posedge clk);
        if (stray)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= CFG_DATA_W'($urandom());
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_w = wd[POS_W-1:0];
        cur_h = ht[POS_W-1:0];
    endtask

    // Drop valid and wait until every answer is back, then wait on for trailing ticks
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        item_word_t w;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset stamps read as touched at time zero
        send_query(4'd5, 4'd5, 32'd0, 32'd0);
        send_query(4'd12, 4'd15, 32'd0, '1);
        send_touch(EV_DOWN, 4'd0, 12'd0, 12'd0);
        send_touch(EV_UP, 4'd1, 12'd4095, 12'd4095);
        send_touch(EV_MOVE, 4'd0, 12'd1919, 12'd540);
        send_touch(EV_OTHER, 4'd15, 12'd960, 12'd1079);
        send_touch(EV_DOWN, 4'd15, 12'd2000, 12'd3000);
        w = noise_word();
        w.cmd = CMD_UNUSED;
        send_word(w);
        send_ticks(3);
        send_touch(EV_DOWN, 4'd1, 12'd100, 12'd900);
        send_ticks(2);
        send_query(4'd3, 4'd1, 32'd0, 32'd0);
        // Down time plus an all-ones minimum wraps below now
        send_query(4'd3, 4'd1, '1, 32'd0);
        send_touch(EV_UP, 4'd1, 12'd1800, 12'd100);
        send_query(4'd3, 4'd7, 32'd0, '1);
        send_query(4'd3, 4'd7, 32'd3, 32'd0);
        send_query(4'd0, 4'd0, 32'd5, 32'd5);
        send_query(4'd9, 4'd9, '1, '1);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 61;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 61;
                end
                default:
                begin
                    gap_pct   = 25;
                    stall_pct = 25;
                end
            endcase
            case (phase)
                0: write_settings(16'd4095, 16'd4095, 16'd65535, 1'b0);
                1: write_settings(16'd1, 16'd1, 16'd1, 1'b0);
                // zero extents push every coordinate into the last column and row
                2: write_settings(16'd0, 16'd0, 16'd20, 1'b1);
                3: write_settings(16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
                                  16'($urandom_range(1, 300)), 1'b0);
                4: write_settings({4'($urandom_range(15)), 12'd1920},
                                  {4'($urandom_range(15)), 12'd1080}, 16'd30, 1'b0);
                default: write_settings(16'($urandom_range(1, 4095)),
                                        16'($urandom_range(1, 4095)),
                                        16'($urandom_range(1, 100)), 1'b1);
            endcase
            run_random(265);
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
